@@ hw/rtl/gcke_pkg.sv @@
// Shared types and constants for the group center-of-mass kinetic energy block.
// Holds register indexes, controller command and status structs.
// No dependencies.
`default_nettype none
package gcke_pkg;

   localparam int unsigned GCKE_MAX_GROUPS = 1024;
   localparam int unsigned SUM_W           = 48;
   localparam int unsigned DIV_STEPS       = 48;
   localparam int unsigned CNT_W           = 6;

   localparam logic [2:0] CSR_PPG          = 3'd0;
   localparam logic [2:0] CSR_FIRST_TAG    = 3'd1;
   localparam logic [2:0] CSR_GROUP_COUNT  = 3'd2;
   localparam logic [2:0] CSR_GROUP_SELECT = 3'd3;
   localparam logic [2:0] CSR_MASS         = 3'd4;
   localparam logic [2:0] CSR_TEMP_SCALE   = 3'd5;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [1:0] {
      SQ_LO_LO,
      SQ_HI_LO,
      SQ_HI_HI
   } sq_step_type;

   typedef struct packed {
      logic        load_item;
      logic        div_bin;
      logic        div_mean;
      logic        div_step;
      logic        rd_bin;
      logic        wr_bin;
      logic        count_drop;
      logic        walk_clear;
      logic        walk_next;
      logic        rd_walk;
      logic        clr_write;
      axis_type    axis;
      logic        acc_clear;
      logic        sq_en;
      sq_step_type sq_step;
      logic        mul_en;
      logic        mul_ts;
      logic        mul_first;
      logic        mul_last;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic selected;
      logic below;
      logic last;
      logic bin_ok;
      logic walk_last;
      logic walk_end;
      logic count_zero;
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/gcke_div.sv @@
// Restoring divider, one quotient bit per step: 48-bit dividend, 16-bit divisor.
// Depends on gcke_pkg.
`default_nettype none
module gcke_div (
   input  wire logic                       clock,
   input  wire logic                       start,
   input  wire logic                       step,
   input  wire logic [gcke_pkg::SUM_W-1:0] dividend,
   input  wire logic [15:0]                divisor,
   output logic      [gcke_pkg::SUM_W-1:0] quotient
);
   import gcke_pkg::*;

   logic [15:0]      rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [16:0]      trial;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      ge     = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (step) begin
         rem_in = ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ hw/rtl/gcke_ctrl.sv @@
// Controller state machine: sequences binning, read-modify-write, reduction,
// scaling, emit and the bin clearing sweep. Depends on gcke_pkg.
`default_nettype none
module gcke_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire gcke_pkg::status_type status,
   output gcke_pkg::cmd_type         cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import gcke_pkg::*;

   typedef enum logic [13:0] {
      S_CLEAR     = 14'b00000000000001,
      S_IDLE      = 14'b00000000000010,
      S_CHECK     = 14'b00000000000100,
      S_DIV_BIN   = 14'b00000000001000,
      S_BIN_CHK   = 14'b00000000010000,
      S_RMW_WR    = 14'b00000000100000,
      S_RED_INIT  = 14'b00000001000000,
      S_RED_RD    = 14'b00000010000000,
      S_RED_DIVLD = 14'b00000100000000,
      S_RED_DIV   = 14'b00001000000000,
      S_RED_SQ    = 14'b00010000000000,
      S_SCALE_M   = 14'b00100000000000,
      S_SCALE_T   = 14'b01000000000000,
      S_EMIT      = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   axis_type         axis_ff, axis_in;
   logic             valid_ff, valid_in;
   state_type        after_item;

   always_comb begin
      after_item = status.last ? S_RED_INIT : S_IDLE;
      cmd        = '0;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      axis_in    = axis_ff;
      valid_in   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            cmd.walk_next = 1'b1;
            if (status.walk_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.selected) begin
               state_in = after_item;
            end else if (status.below) begin
               cmd.count_drop = 1'b1;
               state_in       = after_item;
            end else begin
               cmd.div_bin = 1'b1;
               cnt_in      = '0;
               state_in    = S_DIV_BIN;
            end
         end
         S_DIV_BIN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_BIN_CHK;
         end
         S_BIN_CHK: begin
            if (status.bin_ok) begin
               cmd.rd_bin = 1'b1;
               state_in   = S_RMW_WR;
            end else begin
               cmd.count_drop = 1'b1;
               state_in       = after_item;
            end
         end
         S_RMW_WR: begin
            cmd.wr_bin = 1'b1;
            state_in   = after_item;
         end
         S_RED_INIT: begin
            cmd.walk_clear = 1'b1;
            cmd.acc_clear  = 1'b1;
            axis_in        = AXIS_X;
            cnt_in         = '0;
            state_in       = status.count_zero ? S_SCALE_M : S_RED_RD;
         end
         S_RED_RD: begin
            cmd.rd_walk = 1'b1;
            state_in    = S_RED_DIVLD;
         end
         S_RED_DIVLD: begin
            cmd.div_mean = 1'b1;
            cmd.axis     = axis_ff;
            cnt_in       = '0;
            state_in     = S_RED_DIV;
         end
         S_RED_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_RED_SQ;
            end
         end
         S_RED_SQ: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_step = sq_step_type'(cnt_ff[1:0]);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2)) begin
               cnt_in = '0;
               if (axis_ff != AXIS_Z) begin
                  axis_in  = (axis_ff == AXIS_X) ? AXIS_Y : AXIS_Z;
                  state_in = S_RED_DIVLD;
               end else if (status.walk_last) begin
                  state_in = S_SCALE_M;
               end else begin
                  axis_in       = AXIS_X;
                  cmd.walk_next = 1'b1;
                  state_in      = S_RED_RD;
               end
            end
         end
         S_SCALE_M: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_first = cnt_ff == '0;
            cmd.mul_last  = cnt_ff == CNT_W'(3);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = S_SCALE_T;
            end
         end
         S_SCALE_T: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_ts    = 1'b1;
            cmd.mul_first = cnt_ff == '0;
            cmd.mul_last  = cnt_ff == CNT_W'(3);
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.walk_clear = 1'b1;
            valid_in       = 1'b1;
            state_in       = S_CLEAR;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         axis_ff  <= AXIS_X;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

@@ hw/rtl/gcke_dp.sv @@
// Datapath: configuration registers, bin sum memories, shared divider and
// multiplier, wide accumulator and result registers. Depends on gcke_pkg, gcke_div.
`default_nettype none
module gcke_dp #(
   parameter int unsigned MAX_GROUPS = gcke_pkg::GCKE_MAX_GROUPS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire logic [31:0]          req_particle_tag,
   input  wire logic [31:0]          req_group_mask,
   input  wire logic signed [31:0]   req_vel_x,
   input  wire logic signed [31:0]   req_vel_y,
   input  wire logic signed [31:0]   req_vel_z,
   input  wire logic                 req_last,
   input  wire gcke_pkg::cmd_type    cmd,
   output gcke_pkg::status_type      status,
   output logic [63:0]               rsp_energy,
   output logic [15:0]               rsp_dropped
);
   import gcke_pkg::*;

   localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int unsigned CW = $clog2(MAX_GROUPS + 1);

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [31:0] b);
      logic [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {{(SUM_W-31){b[31]}}, b};
      if (s[SUM_W] != s[SUM_W-1])
         return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return s[SUM_W-1:0];
   endfunction

   // configuration
   logic [15:0] ppg_ff;
   logic [31:0] first_tag_ff, select_ff, mass_ff, tscale_ff;
   logic [10:0] gcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppg_ff       <= 16'd1;
         first_tag_ff <= 32'd1;
         gcount_ff    <= 11'd1;
         select_ff    <= 32'd1;
         mass_ff      <= 32'd65536;
         tscale_ff    <= 32'd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PPG:          ppg_ff       <= csr_data[15:0];
            CSR_FIRST_TAG:    first_tag_ff <= csr_data;
            CSR_GROUP_COUNT:  gcount_ff    <= csr_data[10:0];
            CSR_GROUP_SELECT: select_ff    <= csr_data;
            CSR_MASS:         mass_ff      <= csr_data;
            CSR_TEMP_SCALE:   tscale_ff    <= csr_data;
            default:          ;
         endcase
      end
   end

   logic [15:0]   ppg_eff;
   logic [CW-1:0] count;
   assign ppg_eff = (ppg_ff == '0) ? 16'd1 : ppg_ff;
   assign count   = (32'(gcount_ff) > MAX_GROUPS) ? CW'(MAX_GROUPS) : CW'(gcount_ff);

   // captured item
   logic        sel_ff, below_ff, last_ff;
   logic [31:0] diff_ff, vx_ff, vy_ff, vz_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         sel_ff   <= (req_group_mask & select_ff) != '0;
         below_ff <= req_particle_tag < first_tag_ff;
         diff_ff  <= req_particle_tag - first_tag_ff;
         last_ff  <= req_last;
         vx_ff    <= req_vel_x;
         vy_ff    <= req_vel_y;
         vz_ff    <= req_vel_z;
      end
   end

   // bin walk index
   logic [AW-1:0] idx_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.walk_clear) idx_ff <= '0;
      else if (cmd.walk_next)      idx_ff <= idx_ff + 1'b1;
   end

   // divider
   logic [SUM_W-1:0] quo, rd_sel, mag, dvd;
   logic [SUM_W-1:0] rd_x_ff, rd_y_ff, rd_z_ff;

   always_comb begin
      case (cmd.axis)
         AXIS_Y:  rd_sel = rd_y_ff;
         AXIS_Z:  rd_sel = rd_z_ff;
         default: rd_sel = rd_x_ff;
      endcase
      mag = rd_sel[SUM_W-1] ? (~rd_sel + 1'b1) : rd_sel;
      dvd = cmd.div_mean ? mag : SUM_W'(diff_ff);
   end

   gcke_div u_div (
      .clock   (clock),
      .start   (cmd.div_bin | cmd.div_mean),
      .step    (cmd.div_step),
      .dividend(dvd),
      .divisor (ppg_eff),
      .quotient(quo)
   );

   // bin sum memories
   logic [SUM_W-1:0] sum_x_ff [MAX_GROUPS];
   logic [SUM_W-1:0] sum_y_ff [MAX_GROUPS];
   logic [SUM_W-1:0] sum_z_ff [MAX_GROUPS];
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             wr_en;
   logic [SUM_W-1:0] wd_x, wd_y, wd_z;

   always_comb begin
      rd_addr = cmd.rd_walk ? idx_ff : quo[AW-1:0];
      wr_addr = cmd.clr_write ? idx_ff : quo[AW-1:0];
      wr_en   = cmd.clr_write | cmd.wr_bin;
      wd_x    = cmd.clr_write ? '0 : sat_add(rd_x_ff, vx_ff);
      wd_y    = cmd.clr_write ? '0 : sat_add(rd_y_ff, vy_ff);
      wd_z    = cmd.clr_write ? '0 : sat_add(rd_z_ff, vz_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_x_ff[wr_addr] <= wd_x;
         sum_y_ff[wr_addr] <= wd_y;
         sum_z_ff[wr_addr] <= wd_z;
      end
      if (cmd.rd_bin || cmd.rd_walk) begin
         rd_x_ff <= sum_x_ff[rd_addr];
         rd_y_ff <= sum_y_ff[rd_addr];
         rd_z_ff <= sum_z_ff[rd_addr];
      end
   end

   // shared multiplier: squares of the means, then limb-wise scaling
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  carry_ff, carry_in, op_a, op_b;
   logic         ovf_ff, ovf_in;
   logic [63:0]  prod, limb_sum;

   always_comb begin
      op_a = 32'(quo[23:0]);
      op_b = 32'(quo[23:0]);
      if (cmd.mul_en) begin
         op_a = acc_ff[31:0];
         op_b = cmd.mul_ts ? tscale_ff : mass_ff;
      end else if (cmd.sq_step != SQ_LO_LO) begin
         op_a = 32'(quo[47:24]);
         if (cmd.sq_step == SQ_HI_HI) op_b = 32'(quo[47:24]);
      end
      prod     = op_a * op_b;
      limb_sum = prod + 64'(cmd.mul_first ? 32'd0 : carry_ff);
      acc_in   = acc_ff;
      carry_in = carry_ff;
      ovf_in   = ovf_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.mul_en) begin
         acc_in   = {limb_sum[31:0], acc_ff[127:32]};
         carry_in = limb_sum[63:32];
         if (cmd.mul_last && limb_sum[63:32] != '0) ovf_in = 1'b1;
      end else if (cmd.sq_en) begin
         case (cmd.sq_step)
            SQ_HI_LO: acc_in = acc_ff + (128'(prod) << 25);
            SQ_HI_HI: acc_in = acc_ff + (128'(prod) << 48);
            default:  acc_in = acc_ff + 128'(prod);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      carry_ff <= carry_in;
      ovf_ff   <= ovf_in;
   end

   // drop counter and result registers
   logic [15:0] drop_ff;
   logic [63:0] energy_ff;
   logic [15:0] dropped_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.emit)                    drop_ff <= '0;
      else if (cmd.count_drop && drop_ff != '1) drop_ff <= drop_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         energy_ff  <= (ovf_ff || acc_ff[127:96] != '0) ? '1 : acc_ff[95:32];
         dropped_ff <= drop_ff;
      end
   end

   assign rsp_energy  = energy_ff;
   assign rsp_dropped = dropped_ff;

   always_comb begin
      status.selected   = sel_ff;
      status.below      = below_ff;
      status.last       = last_ff;
      status.bin_ok     = quo < SUM_W'(count);
      status.walk_last  = (CW'(idx_ff) + CW'(1)) == count;
      status.walk_end   = idx_ff == AW'(MAX_GROUPS - 1);
      status.count_zero = count == '0;
   end

endmodule
`default_nettype wire

@@ hw/rtl/group_com_kinetic_energy.sv @@
// Center-of-mass kinetic energy of particle groups. Each particle is loaded and checked;
// one that is selected and not below first_tag is binned (48-step bin divider, RMW).
// A last particle then adds a reduction over the bins in use (48-step mean divider per axis),
// then scaling and emit, and then a sweep that zeroes the bins.
// Reset: synchronous; after it the same sweep runs, busy stays high.
// rsp_valid strobes for one cycle; the receiver cannot stall.
`default_nettype none
module group_com_kinetic_energy #(
   parameter int unsigned MAX_GROUPS = gcke_pkg::GCKE_MAX_GROUPS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // particle transfer
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [31:0]        req_particle_tag,
   input  wire logic [31:0]        req_group_mask,
   input  wire logic signed [31:0] req_vel_x,
   input  wire logic signed [31:0] req_vel_y,
   input  wire logic signed [31:0] req_vel_z,
   input  wire logic               req_last,
   // result transfer
   output logic                    rsp_valid,
   output logic [63:0]             rsp_energy,
   output logic [15:0]             rsp_dropped,
   // register writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import gcke_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequence the work: binning, per-bin reduction, scaling, emit, clearing sweep
   gcke_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   // hold the bin sums and do the arithmetic
   gcke_dp #(
      .MAX_GROUPS(MAX_GROUPS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_particle_tag(req_particle_tag),
      .req_group_mask  (req_group_mask),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_vel_z       (req_vel_z),
      .req_last        (req_last),
      .cmd             (cmd),
      .status          (status),
      .rsp_energy      (rsp_energy),
      .rsp_dropped     (rsp_dropped)
   );

   // a result strobe lasts one cycle: the clearing sweep follows every emit
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // no new particle can be taken while a result is shown
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("block idle while result strobe is high");

   // an accepted particle always makes the block busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a particle transfer");

endmodule
`default_nettype wire
